FILE: hw/rtl/pcanon_pkg.sv
// Shared types and constants of the path canonicalizer.
`default_nettype none

package pcanon_pkg;

  localparam int BUF_BYTES_DEF      = 512;
  localparam int MAX_COMPONENTS_DEF = 128;
  localparam int WORD_BYTES_DEF     = 8;

  localparam int LIMIT_W = 13;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd512;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [2:0] STATUS_OK       = 3'd0;
  localparam logic [2:0] STATUS_EMPTY    = 3'd1;
  localparam logic [2:0] STATUS_TOO_LONG = 3'd2;
  localparam logic [2:0] STATUS_ABOVE    = 3'd3;
  localparam logic [2:0] STATUS_OVERFLOW = 3'd4;

  localparam logic PART_CWD  = 1'b0;
  localparam logic PART_PATH = 1'b1;

  typedef struct packed {
    logic [7:0] char_in;
    logic       has_byte;
    logic       part;
    logic       end_of_request;
  } in_item_t;

  typedef struct packed {
    logic [63:0] word_out;
    logic [3:0]  byte_count;
    logic [2:0]  status;
    logic        last_word;
  } out_item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/path_canonicalizer_core.sv
// Path canonicalizer: resolves a requested path against a working directory.
// Input beats are taken one per cycle while idle; bytes go to their part memory until a NUL
// or a full buffer. After end_of_request the text is scanned byte by byte (memory read,
// then process), with an extra step per component start and per '..' pop, then checks.
// Each output beat comes from one result row read; an error gives a single beat.
// Synchronous active-low reset clears control state; byte and stack memories are not cleared.
`default_nettype none

module path_canonicalizer_core #(
  parameter int BUF_BYTES      = pcanon_pkg::BUF_BYTES_DEF,
  parameter int MAX_COMPONENTS = pcanon_pkg::MAX_COMPONENTS_DEF,
  parameter int WORD_BYTES     = pcanon_pkg::WORD_BYTES_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  pcanon_pkg::in_item_t          in_data,
  output logic                          out_valid,
  input  wire                           out_stall,
  output pcanon_pkg::out_item_t         out_data,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [pcanon_pkg::LIMIT_W-1:0] cfg_data
);

  localparam int AW     = $clog2(BUF_BYTES);
  localparam int LNW    = $clog2(BUF_BYTES + 1);
  localparam int ROWS   = (BUF_BYTES + WORD_BYTES - 1) / WORD_BYTES;
  localparam int RAW    = $clog2(ROWS);
  localparam int ROW_W  = $clog2(ROWS + 1);
  localparam int LANE_W = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;
  localparam int SAW    = $clog2(MAX_COMPONENTS);
  localparam int CNW    = $clog2(MAX_COMPONENTS + 1);
  localparam int STK_W  = ROW_W + LANE_W;
  localparam int TOT_W  = ROW_W + 4;
  localparam int CMP_W  = (TOT_W > pcanon_pkg::LIMIT_W) ? TOT_W : pcanon_pkg::LIMIT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_RD, S_PROC, S_PUT, S_POPW, S_FIN, S_LEN, S_ERD, S_EWAIT, S_ERR
  } state_t;

  typedef enum logic [1:0] {
    SRC_CWD, SRC_SEP, SRC_PATH, SRC_END
  } src_t;

  state_t state_r, state_nxt;
  src_t   src_r, src_nxt;

  logic [pcanon_pkg::LIMIT_W-1:0] limit_r;
  logic [LNW-1:0]    cwd_len_r, cwd_len_nxt;
  logic [LNW-1:0]    path_len_r, path_len_nxt;
  logic              cwd_closed_r, cwd_closed_nxt;
  logic              path_closed_r, path_closed_nxt;
  logic              abs_r, abs_nxt;
  logic              cwd_slash_r, cwd_slash_nxt;
  logic [LNW-1:0]    idx_r, idx_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [LANE_W-1:0] lane_r, lane_nxt;
  logic [ROW_W-1:0]  comp_row_r, comp_row_nxt;
  logic [LANE_W-1:0] comp_lane_r, comp_lane_nxt;
  logic [1:0]        clen_r, clen_nxt;
  logic              dots_r, dots_nxt;
  logic [7:0]        pend_r, pend_nxt;
  logic [CNW-1:0]    count_r, count_nxt;
  logic [2:0]        status_r, status_nxt;
  logic [ROW_W-1:0]  last_row_r, last_row_nxt;
  logic [3:0]        last_cnt_r, last_cnt_nxt;
  logic [ROW_W-1:0]  erow_r, erow_nxt;
  logic              out_valid_r, out_valid_nxt;
  pcanon_pkg::out_item_t out_data_r, out_data_nxt;

  logic [7:0]        cwd_mem [BUF_BYTES];
  logic [7:0]        path_mem [BUF_BYTES];
  logic [7:0]        cwd_rd_r, path_rd_r;
  logic              cwd_we, path_we, cwd_re, path_re;

  logic [STK_W-1:0]  stk_mem [MAX_COMPONENTS];
  logic [STK_W-1:0]  stk_rd_r;
  logic              stk_we, stk_re;
  logic [CNW-1:0]    cnt_dec;

  logic              res_we, res_re;
  logic [7:0]        res_wdata;
  logic [8*WORD_BYTES-1:0] res_word;
  logic [8*WORD_BYTES-1:0] res_mask;

  logic              in_acc, slot_free, sep, too_long;
  logic [LNW:0]      rel_len;
  logic [ROW_W-1:0]  inc_row;
  logic [LANE_W-1:0] inc_lane;
  logic [7:0]        cur_byte;
  logic              cur_slash;
  state_t            after_state;
  logic [TOT_W-1:0]  total;
  logic [3:0]        emit_cnt;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_acc    = in_valid && (state_r == S_IDLE);
  assign slot_free = !out_valid_r || !out_stall;
  assign sep       = (cwd_len_r != '0) && !cwd_slash_r;
  assign rel_len   = (LNW+1)'(cwd_len_r) + (LNW+1)'(sep) + (LNW+1)'(path_len_r);
  assign too_long  = abs_r ? (path_len_r >= LNW'(BUF_BYTES))
                           : (rel_len >= (LNW+1)'(BUF_BYTES));
  assign cnt_dec   = count_r - CNW'(1);
  assign total     = TOT_W'(row_r) * TOT_W'(WORD_BYTES) + TOT_W'(lane_r);
  assign emit_cnt  = (erow_r == last_row_r) ? last_cnt_r : 4'(WORD_BYTES);

  always_comb begin
    if (lane_r == LANE_W'(WORD_BYTES - 1)) begin
      inc_lane = '0;
      inc_row  = row_r + ROW_W'(1);
    end else begin
      inc_lane = lane_r + LANE_W'(1);
      inc_row  = row_r;
    end
  end

  always_comb begin
    case (src_r)
      SRC_CWD:  cur_byte = cwd_rd_r;
      SRC_PATH: cur_byte = path_rd_r;
      default:  cur_byte = pcanon_pkg::CH_SLASH;
    endcase
    cur_slash = (cur_byte == pcanon_pkg::CH_SLASH);
    after_state = (src_r == SRC_END) ? S_FIN : S_RD;
  end

  always_comb begin
    for (int l = 0; l < WORD_BYTES; l++) begin
      res_mask[8*l +: 8] = (4'(l) < emit_cnt) ? 8'hFF : 8'h00;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    src_nxt         = src_r;
    cwd_len_nxt     = cwd_len_r;
    path_len_nxt    = path_len_r;
    cwd_closed_nxt  = cwd_closed_r;
    path_closed_nxt = path_closed_r;
    abs_nxt         = abs_r;
    cwd_slash_nxt   = cwd_slash_r;
    idx_nxt         = idx_r;
    row_nxt         = row_r;
    lane_nxt        = lane_r;
    comp_row_nxt    = comp_row_r;
    comp_lane_nxt   = comp_lane_r;
    clen_nxt        = clen_r;
    dots_nxt        = dots_r;
    pend_nxt        = pend_r;
    count_nxt       = count_r;
    status_nxt      = status_r;
    last_row_nxt    = last_row_r;
    last_cnt_nxt    = last_cnt_r;
    erow_nxt        = erow_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_data_nxt    = out_data_r;
    cwd_we          = 1'b0;
    path_we         = 1'b0;
    cwd_re          = 1'b0;
    path_re         = 1'b0;
    stk_we          = 1'b0;
    stk_re          = 1'b0;
    res_we          = 1'b0;
    res_re          = 1'b0;
    res_wdata       = pcanon_pkg::CH_SLASH;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.has_byte) begin
            if (in_data.part == pcanon_pkg::PART_CWD) begin
              if (!cwd_closed_r) begin
                if (in_data.char_in == pcanon_pkg::CH_NUL) begin
                  cwd_closed_nxt = 1'b1;
                end else if (cwd_len_r < LNW'(BUF_BYTES)) begin
                  cwd_we        = 1'b1;
                  cwd_len_nxt   = cwd_len_r + LNW'(1);
                  cwd_slash_nxt = (in_data.char_in == pcanon_pkg::CH_SLASH);
                end
              end
            end else begin
              if (!path_closed_r) begin
                if (in_data.char_in == pcanon_pkg::CH_NUL) begin
                  path_closed_nxt = 1'b1;
                end else if (path_len_r < LNW'(BUF_BYTES)) begin
                  path_we      = 1'b1;
                  path_len_nxt = path_len_r + LNW'(1);
                  if (path_len_r == '0) begin
                    abs_nxt = (in_data.char_in == pcanon_pkg::CH_SLASH);
                  end
                end
              end
            end
          end
          if (in_data.end_of_request) begin
            state_nxt = S_START;
          end
        end
      end

      S_START: begin
        if ((limit_r == '0) || (path_len_r == '0)) begin
          status_nxt = pcanon_pkg::STATUS_EMPTY;
          state_nxt  = S_ERR;
        end else if (too_long) begin
          status_nxt = pcanon_pkg::STATUS_TOO_LONG;
          state_nxt  = S_ERR;
        end else begin
          src_nxt   = abs_r ? SRC_PATH : SRC_CWD;
          idx_nxt   = '0;
          row_nxt   = '0;
          lane_nxt  = '0;
          count_nxt = '0;
          clen_nxt  = '0;
          dots_nxt  = 1'b0;
          state_nxt = S_RD;
        end
      end

      S_RD: begin
        case (src_r)
          SRC_CWD: begin
            if (idx_r == cwd_len_r) begin
              src_nxt = sep ? SRC_SEP : SRC_PATH;
              idx_nxt = '0;
            end else begin
              cwd_re    = 1'b1;
              idx_nxt   = idx_r + LNW'(1);
              state_nxt = S_PROC;
            end
          end
          SRC_SEP: begin
            state_nxt = S_PROC;
          end
          SRC_PATH: begin
            if (idx_r == path_len_r) begin
              src_nxt = SRC_END;
            end else begin
              path_re = 1'b1;
              idx_nxt = idx_r + LNW'(1);
            end
            state_nxt = S_PROC;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end

      S_PROC: begin
        if (src_r == SRC_SEP) begin
          src_nxt = SRC_PATH;
        end
        state_nxt = after_state;
        if (!cur_slash) begin
          res_we   = 1'b1;
          row_nxt  = inc_row;
          lane_nxt = inc_lane;
          if (clen_r == '0) begin
            res_wdata     = pcanon_pkg::CH_SLASH;
            comp_row_nxt  = row_r;
            comp_lane_nxt = lane_r;
            pend_nxt      = cur_byte;
            clen_nxt      = 2'd1;
            dots_nxt      = (cur_byte == pcanon_pkg::CH_DOT);
            state_nxt     = S_PUT;
          end else begin
            res_wdata = cur_byte;
            clen_nxt  = (clen_r == 2'd3) ? 2'd3 : clen_r + 2'd1;
            dots_nxt  = dots_r && (cur_byte == pcanon_pkg::CH_DOT);
          end
        end else if (clen_r != '0) begin
          clen_nxt = '0;
          if ((clen_r == 2'd1) && dots_r) begin
            row_nxt  = comp_row_r;
            lane_nxt = comp_lane_r;
          end else if ((clen_r == 2'd2) && dots_r) begin
            if (count_r == '0) begin
              status_nxt = pcanon_pkg::STATUS_ABOVE;
              state_nxt  = S_ERR;
            end else begin
              stk_re    = 1'b1;
              state_nxt = S_POPW;
            end
          end else begin
            stk_we    = 1'b1;
            count_nxt = count_r + CNW'(1);
            if (count_r == CNW'(MAX_COMPONENTS - 1)) begin
              state_nxt = S_FIN;
            end
          end
        end
      end

      S_PUT: begin
        res_we    = 1'b1;
        res_wdata = pend_r;
        row_nxt   = inc_row;
        lane_nxt  = inc_lane;
        state_nxt = S_RD;
      end

      S_POPW: begin
        row_nxt   = stk_rd_r[STK_W-1 -: ROW_W];
        lane_nxt  = stk_rd_r[LANE_W-1:0];
        count_nxt = cnt_dec;
        state_nxt = after_state;
      end

      S_FIN: begin
        if (count_r == '0) begin
          res_we   = 1'b1;
          row_nxt  = inc_row;
          lane_nxt = inc_lane;
        end
        state_nxt = S_LEN;
      end

      S_LEN: begin
        if (CMP_W'(total) >= CMP_W'(limit_r)) begin
          status_nxt = pcanon_pkg::STATUS_OVERFLOW;
          state_nxt  = S_ERR;
        end else begin
          if (lane_r == '0) begin
            last_row_nxt = row_r - ROW_W'(1);
            last_cnt_nxt = 4'(WORD_BYTES);
          end else begin
            last_row_nxt = row_r;
            last_cnt_nxt = 4'(lane_r);
          end
          erow_nxt  = '0;
          state_nxt = S_ERD;
        end
      end

      S_ERD: begin
        res_re    = 1'b1;
        state_nxt = S_EWAIT;
      end

      S_EWAIT: begin
        if (slot_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.word_out   = 64'(res_word & res_mask);
          out_data_nxt.byte_count = emit_cnt;
          out_data_nxt.status     = pcanon_pkg::STATUS_OK;
          out_data_nxt.last_word  = (erow_r == last_row_r);
          if (erow_r == last_row_r) begin
            state_nxt = S_IDLE;
          end else begin
            erow_nxt  = erow_r + ROW_W'(1);
            state_nxt = S_ERD;
          end
        end
      end

      S_ERR: begin
        if (slot_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.word_out   = '0;
          out_data_nxt.byte_count = '0;
          out_data_nxt.status     = status_r;
          out_data_nxt.last_word  = 1'b1;
          state_nxt               = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // drop the request state once the request is finished
    if ((state_r != S_IDLE) && (state_nxt == S_IDLE)) begin
      cwd_len_nxt     = '0;
      path_len_nxt    = '0;
      cwd_closed_nxt  = 1'b0;
      path_closed_nxt = 1'b0;
      abs_nxt         = 1'b0;
      cwd_slash_nxt   = 1'b0;
      count_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      src_r         <= SRC_CWD;
      limit_r       <= pcanon_pkg::LIMIT_RESET;
      cwd_len_r     <= '0;
      path_len_r    <= '0;
      cwd_closed_r  <= 1'b0;
      path_closed_r <= 1'b0;
      abs_r         <= 1'b0;
      cwd_slash_r   <= 1'b0;
      count_r       <= '0;
      clen_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      src_r         <= src_nxt;
      if (cfg_valid) begin
        limit_r <= cfg_data;
      end
      cwd_len_r     <= cwd_len_nxt;
      path_len_r    <= path_len_nxt;
      cwd_closed_r  <= cwd_closed_nxt;
      path_closed_r <= path_closed_nxt;
      abs_r         <= abs_nxt;
      cwd_slash_r   <= cwd_slash_nxt;
      count_r       <= count_nxt;
      clen_r        <= clen_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    idx_r       <= idx_nxt;
    row_r       <= row_nxt;
    lane_r      <= lane_nxt;
    comp_row_r  <= comp_row_nxt;
    comp_lane_r <= comp_lane_nxt;
    dots_r      <= dots_nxt;
    pend_r      <= pend_nxt;
    status_r    <= status_nxt;
    last_row_r  <= last_row_nxt;
    last_cnt_r  <= last_cnt_nxt;
    erow_r      <= erow_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (cwd_we) begin
      cwd_mem[cwd_len_r[AW-1:0]] <= in_data.char_in;
    end
    if (cwd_re) begin
      cwd_rd_r <= cwd_mem[idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (path_we) begin
      path_mem[path_len_r[AW-1:0]] <= in_data.char_in;
    end
    if (path_re) begin
      path_rd_r <= path_mem[idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[count_r[SAW-1:0]] <= {comp_row_r, comp_lane_r};
    end
    if (stk_re) begin
      stk_rd_r <= stk_mem[cnt_dec[SAW-1:0]];
    end
  end

  for (genvar g = 0; g < WORD_BYTES; g++) begin : g_lane
    logic [7:0] lane_mem [ROWS];
    logic [7:0] lane_rd_r;

    always_ff @(posedge clk) begin
      if (res_we && (lane_r == LANE_W'(g))) begin
        lane_mem[row_r[RAW-1:0]] <= res_wdata;
      end
      if (res_re) begin
        lane_rd_r <= lane_mem[erow_r[RAW-1:0]];
      end
    end

    assign res_word[8*g +: 8] = lane_rd_r;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pcanon_checker.sv
// Port-level checks of the path canonicalizer, bound to path_canonicalizer_core.
`default_nettype none

module pcanon_checker #(
  parameter int WORD_BYTES = pcanon_pkg::WORD_BYTES_DEF
) (
  input wire                           clk,
  input wire                           rst_n,
  input wire                           in_valid,
  input wire                           in_stall,
  input pcanon_pkg::in_item_t          in_data,
  input wire                           out_valid,
  input wire                           out_stall,
  input pcanon_pkg::out_item_t         out_data,
  input wire                           cfg_valid,
  input wire                           cfg_ready,
  input wire [pcanon_pkg::LIMIT_W-1:0] cfg_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != pcanon_pkg::STATUS_OK) |->
      out_data.last_word && (out_data.byte_count == 4'd0) && (out_data.word_out == 64'd0))
    else $error("error beat carries data or is not last");

  a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == pcanon_pkg::STATUS_OK) && !out_data.last_word |->
      (out_data.byte_count == 4'(WORD_BYTES)))
    else $error("non-final result beat is not a full word");

  a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == pcanon_pkg::STATUS_OK) |->
      (out_data.byte_count != 4'd0) && (out_data.byte_count <= 4'(WORD_BYTES)))
    else $error("result beat byte count out of range");

  a_busy_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.end_of_request && cfg_ready |=> in_stall)
    else $error("input taken right after end of request");

endmodule

bind path_canonicalizer_core pcanon_checker #(.WORD_BYTES(WORD_BYTES)) u_pcanon_checker (.*);

`default_nettype wire

FILE: sim/tb.sv
// Testbench for path_canonicalizer_core: queued random and directed requests, scoreboard check.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcanon_pkg::*;

  localparam int BUF         = BUF_BYTES_DEF;
  localparam int MAXC        = MAX_COMPONENTS_DEF;
  localparam int WB          = WORD_BYTES_DEF;
  localparam int SETTLE      = 24;
  localparam int QUIET_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [LIMIT_W-1:0] cfg_data = '0;

  path_canonicalizer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // canonicalizer state mirror
  logic [7:0] cwd_buf [BUF];
  logic [7:0] path_buf [BUF];
  int unsigned cwd_len_q = 0;
  int unsigned path_len_q = 0;
  bit cwd_done = 1'b0;
  bit path_done = 1'b0;
  logic [LIMIT_W-1:0] limit_q = LIMIT_RESET;

  in_item_t  beat_q [$];
  out_item_t expected_words [$];
  logic [7:0] cwd_s [$];
  logic [7:0] path_s [$];

  int mismatches = 0;
  int items_made = 0;
  int reqs_made = 0;
  int quiet_cycles = 0;
  bit in_took = 1'b0;
  bit in_calm = 1'b0;
  int in_gap = 0;
  bit out_took = 1'b0;
  bit out_calm = 1'b0;
  int out_wait = 0;
  out_item_t want;

  task automatic report(input string what);
    $display("ERROR t=%0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic int pick_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  task automatic take_byte(input logic p, input logic [7:0] c);
    if (p == PART_PATH) begin
      if (!path_done) begin
        if (c == CH_NUL) path_done = 1'b1;
        else if (path_len_q < BUF) begin
          path_buf[path_len_q] = c;
          path_len_q++;
        end
      end
    end else begin
      if (!cwd_done) begin
        if (c == CH_NUL) cwd_done = 1'b1;
        else if (cwd_len_q < BUF) begin
          cwd_buf[cwd_len_q] = c;
          cwd_len_q++;
        end
      end
    end
  endtask

  task automatic resolve_request();
    logic [7:0] comb [BUF];
    logic [7:0] res [BUF];
    int unsigned starts [MAXC];
    int unsigned lens [MAXC];
    int unsigned n, i, start, t, cnt, used, k, b, sep, words, idx;
    logic [2:0] st;
    bit stop;
    out_item_t o;
    st = STATUS_OK;
    n = 0;
    cnt = 0;
    used = 0;
    if (limit_q == 0 || path_len_q == 0) begin
      st = STATUS_EMPTY;
    end else if (path_buf[0] == CH_SLASH) begin
      if (path_len_q >= BUF) st = STATUS_TOO_LONG;
      else begin
        for (i = 0; i < path_len_q; i++) comb[i] = path_buf[i];
        n = path_len_q;
      end
    end else begin
      sep = (cwd_len_q > 0 && cwd_buf[cwd_len_q-1] != CH_SLASH) ? 1 : 0;
      if (cwd_len_q + sep + path_len_q >= BUF) st = STATUS_TOO_LONG;
      else begin
        for (i = 0; i < cwd_len_q; i++) comb[i] = cwd_buf[i];
        n = cwd_len_q;
        if (sep != 0) begin
          comb[n] = CH_SLASH;
          n++;
        end
        for (i = 0; i < path_len_q; i++) comb[n+i] = path_buf[i];
        n += path_len_q;
      end
    end
    if (st == STATUS_OK) begin
      i = 0;
      stop = 1'b0;
      while (!stop && i < n && cnt < MAXC) begin
        while (i < n && comb[i] == CH_SLASH) i++;
        if (i >= n) stop = 1'b1;
        else begin
          start = i;
          while (i < n && comb[i] != CH_SLASH) i++;
          t = i - start;
          if (t == 1 && comb[start] == CH_DOT) begin
          end else if (t == 2 && comb[start] == CH_DOT && comb[start+1] == CH_DOT) begin
            if (cnt == 0) begin
              st = STATUS_ABOVE;
              stop = 1'b1;
            end else cnt--;
          end else begin
            starts[cnt] = start;
            lens[cnt] = t;
            cnt++;
          end
        end
      end
    end
    if (st == STATUS_OK) begin
      if (cnt == 0) begin
        if (limit_q < 2) st = STATUS_OVERFLOW;
        else begin
          res[0] = CH_SLASH;
          used = 1;
        end
      end else begin
        for (k = 0; k < cnt && st == STATUS_OK; k++) begin
          t = lens[k];
          if (used + t + 2 > limit_q || used + 1 + t > BUF) st = STATUS_OVERFLOW;
          else begin
            res[used] = CH_SLASH;
            used++;
            for (i = 0; i < t; i++) res[used+i] = comb[starts[k]+i];
            used += t;
          end
        end
      end
    end
    cwd_len_q = 0;
    path_len_q = 0;
    cwd_done = 1'b0;
    path_done = 1'b0;
    if (st != STATUS_OK) begin
      o.word_out = '0;
      o.byte_count = '0;
      o.status = st;
      o.last_word = 1'b1;
      expected_words.push_back(o);
    end else begin
      words = (used + WB - 1) / WB;
      for (k = 0; k < words; k++) begin
        o.word_out = '0;
        o.byte_count = '0;
        for (b = 0; b < WB; b++) begin
          idx = k * WB + b;
          if (idx < used) begin
            o.word_out[8*b +: 8] = res[idx];
            o.byte_count = o.byte_count + 4'd1;
          end
        end
        o.status = STATUS_OK;
        o.last_word = (k + 1 == words);
        expected_words.push_back(o);
      end
    end
  endtask

  task automatic canon_step(input in_item_t it);
    if (it.has_byte) take_byte(it.part, it.char_in);
    if (it.end_of_request) resolve_request();
  endtask

  // stimulus building
  task automatic put(input bit p, input logic [7:0] c);
    if (p) path_s.push_back(c);
    else cwd_s.push_back(c);
  endtask

  task automatic text(input bit p, input string s);
    int j;
    for (j = 0; j < s.len(); j++) put(p, s[j]);
  endtask

  task automatic add_tokens(input bit p, input int cnt);
    int j, q, n;
    logic [7:0] c;
    for (j = 0; j < cnt; j++) begin
      case ($urandom_range(0, 9))
        0, 1: put(p, CH_DOT);
        2, 3: begin
          put(p, CH_DOT);
          put(p, CH_DOT);
        end
        4: ;
        5: repeat (3) put(p, CH_DOT);
        default: begin
          n = $urandom_range(1, 4);
          for (q = 0; q < n; q++) begin
            case ($urandom_range(0, 3))
              0: c = "a";
              1: c = "b";
              2: c = CH_DOT;
              default: begin
                c = $urandom_range(1, 255);
                if (c == CH_SLASH) c = "c";
              end
            endcase
            put(p, c);
          end
        end
      endcase
      if (j + 1 < cnt || $urandom_range(0, 3) == 0) put(p, CH_SLASH);
    end
  endtask

  task automatic emit_request(input bit mix, input bit tail_marker, input bit markers);
    in_item_t stage [$];
    in_item_t it;
    bit use_path;
    while (cwd_s.size() > 0 || path_s.size() > 0) begin
      if (markers && $urandom_range(0, 7) == 0) begin
        it.char_in = $urandom_range(0, 255);
        it.has_byte = 1'b0;
        it.part = $urandom_range(0, 1);
        it.end_of_request = 1'b0;
        stage.push_back(it);
      end
      if (cwd_s.size() == 0) use_path = 1'b1;
      else if (path_s.size() == 0) use_path = 1'b0;
      else use_path = mix ? $urandom_range(0, 1) : 1'b0;
      it.char_in = use_path ? path_s.pop_front() : cwd_s.pop_front();
      it.has_byte = 1'b1;
      it.part = use_path ? PART_PATH : PART_CWD;
      it.end_of_request = 1'b0;
      stage.push_back(it);
    end
    if (tail_marker || stage.size() == 0) begin
      it.char_in = $urandom_range(0, 255);
      it.has_byte = 1'b0;
      it.part = $urandom_range(0, 1);
      it.end_of_request = 1'b1;
      stage.push_back(it);
    end else begin
      it = stage.pop_back();
      it.end_of_request = 1'b1;
      stage.push_back(it);
    end
    foreach (stage[k]) beat_q.push_back(stage[k]);
    items_made += stage.size();
    reqs_made++;
  endtask

  task automatic random_request(input int forced_kind);
    int kind, j, len;
    logic [7:0] c;
    cwd_s.delete();
    path_s.delete();
    kind = (forced_kind >= 0) ? forced_kind : $urandom_range(0, 99);
    if (kind < 70) begin
      if ($urandom_range(0, 2) != 0) begin
        if ($urandom_range(0, 3) != 0) put(0, CH_SLASH);
        add_tokens(0, $urandom_range(0, 4));
      end
      if ($urandom_range(0, 1) == 1) put(1, CH_SLASH);
      add_tokens(1, $urandom_range(1, 5));
      emit_request($urandom_range(0, 3) == 0, $urandom_range(0, 4) == 0,
                   $urandom_range(0, 4) == 0);
    end else if (kind < 85) begin
      len = $urandom_range(0, 12);
      for (j = 0; j < len; j++) put($urandom_range(0, 1), $urandom_range(0, 255));
      emit_request(1'b1, $urandom_range(0, 1), $urandom_range(0, 1));
    end else if (kind < 92) begin
      add_tokens(0, $urandom_range(0, 3));
      case ($urandom_range(0, 2))
        0: begin
          put(1, CH_SLASH);
          add_tokens(1, $urandom_range(1, 3));
          put(1, CH_NUL);
          repeat ($urandom_range(1, 4)) put(1, $urandom_range(0, 255));
        end
        1: ;
        default: begin
          put(1, CH_NUL);
          add_tokens(1, $urandom_range(1, 3));
        end
      endcase
      if ($urandom_range(0, 1) == 1) begin
        put(0, CH_NUL);
        put(0, $urandom_range(0, 255));
      end
      emit_request($urandom_range(0, 1), $urandom_range(0, 1), 1'b1);
    end else if (kind < 96) begin
      put(1, CH_SLASH);
      repeat ($urandom_range(124, 134)) begin
        put(1, $urandom_range(0, 1) ? "a" : "b");
        put(1, CH_SLASH);
      end
      add_tokens(1, $urandom_range(1, 3));
      emit_request(1'b0, 1'b0, 1'b0);
    end else begin
      if ($urandom_range(0, 3) == 0) begin
        put(1, CH_SLASH);
        len = $urandom_range(508, 530);
        for (j = 1; j < len; j++) begin
          c = ($urandom_range(0, 3) == 0) ? CH_SLASH : "a";
          put(1, c);
        end
      end else begin
        put(0, CH_SLASH);
        len = $urandom_range(495, 515);
        for (j = 1; j < len; j++) begin
          case ($urandom_range(0, 5))
            0: c = CH_SLASH;
            1: c = CH_DOT;
            default: c = "a";
          endcase
          put(0, c);
        end
        add_tokens(1, $urandom_range(1, 3));
      end
      emit_request(1'b0, 1'b0, 1'b0);
    end
  endtask

  task automatic drain();
    while (beat_q.size() != 0 || in_valid || expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    limit_q = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      canon_step(in_data);
      in_took = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      in_took = 1'b0;
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (beat_q.size() > 0) begin
        in_data <= beat_q.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 19) == 0) in_calm = !in_calm;
        in_gap = pick_wait(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      out_took = 1'b1;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected beat word=%h count=%0d status=%0d last=%0b",
                         out_data.word_out, out_data.byte_count, out_data.status,
                         out_data.last_word));
      end else begin
        want = expected_words.pop_front();
        if (out_data.word_out !== want.word_out)
          report($sformatf("word_out %h, want %h", out_data.word_out, want.word_out));
        if (out_data.byte_count !== want.byte_count)
          report($sformatf("byte_count %0d, want %0d", out_data.byte_count, want.byte_count));
        if (out_data.status !== want.status)
          report($sformatf("status %0d, want %0d", out_data.status, want.status));
        if (out_data.last_word !== want.last_word)
          report($sformatf("last_word %0b, want %0b", out_data.last_word, want.last_word));
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_took) begin
        out_took = 1'b0;
        if ($urandom_range(0, 19) == 0) out_calm = !out_calm;
        out_wait = pick_wait(out_calm);
      end
      if (out_wait > 0) begin
        out_stall <= 1'b1;
        if (out_valid) out_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    text(1, "/");
    emit_request(1'b0, 1'b0, 1'b0);
    emit_request(1'b0, 1'b0, 1'b0);
    text(1, "/..");
    emit_request(1'b0, 1'b0, 1'b0);
    text(0, "a");
    text(1, "b/.");
    emit_request(1'b0, 1'b0, 1'b1);
    text(0, "x/");
    text(1, "..");
    emit_request(1'b0, 1'b0, 1'b0);
    text(1, "/q");
    put(1, CH_NUL);
    text(1, "z");
    emit_request(1'b0, 1'b0, 1'b0);
    put(0, 8'hFF);
    text(0, "c");
    text(1, "d");
    emit_request(1'b1, 1'b1, 1'b0);
    repeat (10) random_request(-1);
    drain();

    write_limit('0);
    text(1, "/a");
    emit_request(1'b0, 1'b0, 1'b0);
    repeat (3) random_request(-1);
    drain();

    write_limit(13'd1);
    text(1, "/");
    emit_request(1'b0, 1'b0, 1'b0);
    text(1, "/a");
    emit_request(1'b0, 1'b0, 1'b0);
    repeat (3) random_request(-1);
    drain();

    write_limit(13'd2);
    text(1, "/.");
    emit_request(1'b0, 1'b0, 1'b0);
    text(1, "/a");
    emit_request(1'b0, 1'b0, 1'b0);
    repeat (3) random_request(-1);
    drain();

    write_limit($urandom_range(3, 24));
    repeat (10) random_request(-1);
    drain();

    write_limit('1);
    random_request(96);
    random_request(92);
    repeat (8) random_request(-1);
    drain();

    write_limit(13'd4096);
    repeat (8) random_request(-1);
    drain();

    write_limit($urandom_range(0, 8191));
    repeat (8) random_request(-1);
    drain();

    write_limit(LIMIT_RESET);
    while (reqs_made < 60) random_request(-1);
    drain();

    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
